/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with asynchronous active-low reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, with the reset also held off the antecedent
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/core/srst_pkg.sv */
`default_nettype none
package srst_pkg;
    localparam int VEL_W    = 32;
    localparam int ACC_W    = 32;
    localparam int DIST_W   = 24;
    localparam int RAD_W    = 64;
    localparam int SQ_REM_W = 34;
    localparam int SQ_STAGES  = 32;
    localparam int DIV_STAGES = 32;

    localparam logic [0:0] IDX_ACCEL = 1'b0;
    localparam logic [0:0] IDX_DIST  = 1'b1;

    localparam logic [ACC_W-1:0]  ACCEL_RESET = 32'd32768000;
    localparam logic [DIST_W-1:0] DIST_RESET  = 24'd41943;
    localparam logic [VEL_W-1:0]  VEL_MAX     = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [VEL_W-1:0]    root;
    } sq_t;

    typedef struct packed {
        logic [ACC_W-1:0] rem;
        logic [VEL_W-1:0] quo;
    } dv_t;

    // one root digit: bring down two radicand bits and try the next bit
    function automatic sq_t sq_step(input sq_t cur, input logic [1:0] pair);
        logic [SQ_REM_W+1:0] rem_sh;
        logic [SQ_REM_W+1:0] trial;
        sq_t res;
        rem_sh = {cur.rem, pair};
        trial  = {2'b00, cur.root, 2'b01};
        if (rem_sh >= trial)
        begin
            res.rem  = SQ_REM_W'(rem_sh - trial);
            res.root = {cur.root[VEL_W-2:0], 1'b1};
        end
        else
        begin
            res.rem  = rem_sh[SQ_REM_W-1:0];
            res.root = {cur.root[VEL_W-2:0], 1'b0};
        end
        return res;
    endfunction

    // one quotient bit of a restoring divide, partial remainder below divisor
    function automatic dv_t dv_step(input dv_t cur, input logic [ACC_W-1:0] dvs);
        logic [ACC_W:0] rem_sh;
        dv_t res;
        rem_sh = {cur.rem, 1'b0};
        if (rem_sh >= {1'b0, dvs})
        begin
            res.rem = ACC_W'(rem_sh - {1'b0, dvs});
            res.quo = {cur.quo[VEL_W-2:0], 1'b1};
        end
        else
        begin
            res.rem = rem_sh[ACC_W-1:0];
            res.quo = {cur.quo[VEL_W-2:0], 1'b0};
        end
        return res;
    endfunction
endpackage
`default_nettype wire

/* rtl/core/stepper_ramp_step_timing.sv */
// channel | dir | signals                          | contents
// s       | in  | s_tvalid s_tready s_tdata s_tuser | start_velocity, mode
// m       | out | m_tvalid m_tready m_tdata m_tuser | end_velocity+pulse_delay, underflow
// cfg     | in  | cfg_we cfg_index cfg_data         | accel_rate, step_distance
// an accepted item passes stage 1, stage 2, the 32-stage root pipeline, stage 3, the
// 32-stage delay divider and output register; one item per cycle unless m stalls
// rst_n clears all valid bits and loads the register reset values
// a stall on m freezes every stage at once; s_tready is low only while the
// output register is full and not taken
`default_nettype none
`include "assert_macros.svh"
module stepper_ramp_step_timing (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] start_velocity
    input  wire logic [0:0]  s_tuser,   // [0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [31:0] end_velocity, [63:32] pulse_delay
    output logic [0:0]       m_tuser,   // [0] ramp_underflow
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int SQ_N = srst_pkg::SQ_STAGES;
    localparam int DV_N = srst_pkg::DIV_STAGES;

    // configuration registers
    logic [srst_pkg::ACC_W-1:0]  accel_reg;
    logic [srst_pkg::DIST_W-1:0] dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg <= srst_pkg::ACCEL_RESET;
            dist_reg  <= srst_pkg::DIST_RESET;
        end
        else if (cfg_we && !cfg_index[1])
        begin
            unique case (cfg_index[0])
                srst_pkg::IDX_ACCEL: accel_reg <= cfg_data;
                srst_pkg::IDX_DIST:  dist_reg  <= cfg_data[srst_pkg::DIST_W-1:0];
                default:             accel_reg <= accel_reg;
            endcase
        end
    end

    // whole pipeline moves together unless the output item is stalled
    logic adv;
    logic out_valid_reg;
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    // stage 1: square of start velocity and a*d product
    logic        v1_reg, mode1_reg;
    logic [31:0] vi1_reg;
    logic [63:0] visq1_reg;
    logic [55:0] ad1_reg;

    // stage 2: radicand with clamp and overflow handling
    logic        v2_reg, sat2_reg, under2_reg;
    logic [31:0] vi2_reg;
    logic [63:0] rad2_reg;
    logic [48:0] term;
    logic [64:0] sum;
    logic        sat_next, under_next;
    logic [63:0] rad_next;

    assign term = ad1_reg[55:7];   // (2*a*d) >> 8
    assign sum  = {1'b0, visq1_reg} + {16'b0, term};

    always_comb
    begin
        sat_next   = 1'b0;
        under_next = 1'b0;
        if (mode1_reg)
        begin
            under_next = {15'b0, term} > visq1_reg;
            rad_next   = under_next ? 64'd0 : visq1_reg - {15'b0, term};
        end
        else
        begin
            sat_next = sum[64];
            rad_next = sum[63:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode1_reg  <= s_tuser[0];
            vi1_reg    <= s_tdata;
            visq1_reg  <= 64'(s_tdata) * 64'(s_tdata);
            ad1_reg    <= 56'(accel_reg) * 56'(dist_reg);
            vi2_reg    <= vi1_reg;
            rad2_reg   <= rad_next;
            sat2_reg   <= sat_next;
            under2_reg <= under_next;
        end
    end

    // root pipeline: one result bit per stage
    logic         sq_v_reg     [SQ_N];
    logic [63:0]  sq_x_reg     [SQ_N];
    srst_pkg::sq_t sq_reg      [SQ_N];
    logic         sq_sat_reg   [SQ_N];
    logic         sq_under_reg [SQ_N];
    logic [31:0]  sq_vi_reg    [SQ_N];
    srst_pkg::sq_t sq_next     [SQ_N];

    always_comb
    begin
        for (int k = 0; k < SQ_N; k++)
        begin
            if (k == 0)
                sq_next[k] = srst_pkg::sq_step('0, rad2_reg[63:62]);
            else
                sq_next[k] = srst_pkg::sq_step(sq_reg[k-1], sq_x_reg[k-1][63:62]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SQ_N; k++)
                sq_v_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            for (int k = 0; k < SQ_N; k++)
                sq_v_reg[k] <= (k == 0) ? v2_reg : sq_v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < SQ_N; k++)
            begin
                sq_reg[k] <= sq_next[k];
                if (k == 0)
                begin
                    sq_x_reg[k]     <= {rad2_reg[61:0], 2'b00};
                    sq_sat_reg[k]   <= sat2_reg;
                    sq_under_reg[k] <= under2_reg;
                    sq_vi_reg[k]    <= vi2_reg;
                end
                else
                begin
                    sq_x_reg[k]     <= {sq_x_reg[k-1][61:0], 2'b00};
                    sq_sat_reg[k]   <= sq_sat_reg[k-1];
                    sq_under_reg[k] <= sq_under_reg[k-1];
                    sq_vi_reg[k]    <= sq_vi_reg[k-1];
                end
            end
        end
    end

    // stage 3: end velocity, velocity change, delay saturation check
    logic        v3_reg, under3_reg, big3_reg;
    logic [31:0] vf3_reg, diff3_reg;
    logic [31:0] vf_next, diff_next;

    always_comb
    begin
        vf_next   = sq_sat_reg[SQ_N-1] ? srst_pkg::VEL_MAX : sq_reg[SQ_N-1].root;
        diff_next = (vf_next >= sq_vi_reg[SQ_N-1]) ? vf_next - sq_vi_reg[SQ_N-1]
                                                   : sq_vi_reg[SQ_N-1] - vf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= sq_v_reg[SQ_N-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vf3_reg    <= vf_next;
            diff3_reg  <= diff_next;
            under3_reg <= sq_under_reg[SQ_N-1];
            // quotient reaches 2^32 exactly when diff >= a; zero a lands here too
            big3_reg   <= diff_next >= accel_reg;
        end
    end

    // delay divider: (diff << 32) / a, one quotient bit per stage
    logic          dv_v_reg     [DV_N];
    srst_pkg::dv_t dv_reg       [DV_N];
    logic [31:0]   dv_vf_reg    [DV_N];
    logic          dv_under_reg [DV_N];
    logic          dv_big_reg   [DV_N];
    srst_pkg::dv_t dv_next      [DV_N];

    always_comb
    begin
        for (int k = 0; k < DV_N; k++)
        begin
            if (k == 0)
                dv_next[k] = srst_pkg::dv_step('{rem: diff3_reg, quo: '0}, accel_reg);
            else
                dv_next[k] = srst_pkg::dv_step(dv_reg[k-1], accel_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DV_N; k++)
                dv_v_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            for (int k = 0; k < DV_N; k++)
                dv_v_reg[k] <= (k == 0) ? v3_reg : dv_v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < DV_N; k++)
            begin
                dv_reg[k] <= dv_next[k];
                if (k == 0)
                begin
                    dv_vf_reg[k]    <= vf3_reg;
                    dv_under_reg[k] <= under3_reg;
                    dv_big_reg[k]   <= big3_reg;
                end
                else
                begin
                    dv_vf_reg[k]    <= dv_vf_reg[k-1];
                    dv_under_reg[k] <= dv_under_reg[k-1];
                    dv_big_reg[k]   <= dv_big_reg[k-1];
                end
            end
        end
    end

    // output register
    logic [31:0] out_vf_reg, out_delay_reg;
    logic        out_under_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_v_reg[DV_N-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_vf_reg    <= dv_vf_reg[DV_N-1];
            out_under_reg <= dv_under_reg[DV_N-1];
            out_delay_reg <= dv_big_reg[DV_N-1] ? srst_pkg::VEL_MAX : dv_reg[DV_N-1].quo;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_delay_reg, out_vf_reg};
    assign m_tuser  = out_under_reg;

    // checks
    `ASSERT_CLK(a_ready_rule, clk, rst_n, s_tready == (!m_tvalid || m_tready), "ready rule broken")
    `ASSERT_IMPL(a_under_zero, clk, rst_n, m_tvalid && m_tuser[0], m_tdata[31:0] == 32'd0, "underflow with nonzero velocity")
    `ASSERT_IMPL(a_zero_accel, clk, rst_n, m_tvalid && accel_reg == '0, m_tdata[63:32] == srst_pkg::VEL_MAX, "zero accel delay not saturated")
endmodule
`default_nettype wire
